// ===== rtl/stph_pkg.sv =====
// Shared types and constants for the stereo true-peak hold meter.
`default_nettype none
package stph_pkg;

   // Interpolation ratio; each lane forms OS_FACTOR-1 points between samples.
   // Kept a power of two so the divide by the ratio is an arithmetic shift.
   localparam int OS_FACTOR = 4;
   localparam int OS_SHIFT  = $clog2(OS_FACTOR);

   // Decay multiplier is a 16-bit fraction of one.
   localparam int DECAY_BITS = 16;

   // Configuration register indexes.
   localparam logic REG_DECAY_FACTOR   = 1'b0;
   localparam logic REG_CHANNEL_ENABLE = 1'b1;

   // Control carried from the lane stage to the merge stage.
   typedef struct packed {
      logic valid;
      logic block_end;
   } stage_ctrl_type;

endpackage
`default_nettype wire

// ===== rtl/stph_lane.sv =====
// One channel lane: interpolates between samples and registers the channel peak.
`default_nettype none
module stph_lane
   import stph_pkg::*;
#(
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire logic                          enable,
   input  wire logic signed [SAMPLE_BITS-1:0] sample,
   output logic             [SAMPLE_BITS-1:0] peak
);

   localparam int SUM_W = SAMPLE_BITS + OS_SHIFT + 2;

   logic signed [SAMPLE_BITS-1:0] prev_ff;
   logic signed [SAMPLE_BITS-1:0] prev_in;
   logic        [SAMPLE_BITS-1:0] peak_ff;
   logic        [SAMPLE_BITS-1:0] peak_in;
   logic        [SAMPLE_BITS-1:0] mag_pts [OS_FACTOR];
   logic signed [SUM_W-1:0]       prev_x;
   logic signed [SUM_W-1:0]       curr_x;

   assign prev_x = SUM_W'(prev_ff);
   assign curr_x = SUM_W'(sample);

   // Magnitude of the current sample
   assign mag_pts[0] = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

   // Form each interpolated point and its magnitude
   for (genvar k = 1; k < OS_FACTOR; k++) begin : g_point
      localparam logic signed [SUM_W-1:0] WPREV = SUM_W'(OS_FACTOR - k);
      localparam logic signed [SUM_W-1:0] WCURR = SUM_W'(k);
      logic signed [SUM_W-1:0]       sum;
      logic signed [SUM_W-1:0]       shifted;
      logic        [SAMPLE_BITS-1:0] pt;
      assign sum     = WPREV * prev_x + WCURR * curr_x;
      assign shifted = sum >>> OS_SHIFT;
      assign pt      = shifted[SAMPLE_BITS-1:0];
      assign mag_pts[k] = pt[SAMPLE_BITS-1] ? (~pt + 1'b1) : pt;
   end

   // Pick the largest magnitude; a disabled lane reports zero
   always_comb begin
      logic [SAMPLE_BITS-1:0] best;
      best = mag_pts[0];
      for (int i = 1; i < OS_FACTOR; i++) begin
         if (mag_pts[i] > best) begin
            best = mag_pts[i];
         end
      end
      peak_in = enable ? best : '0;
      prev_in = (load && enable) ? sample : prev_ff;
   end

   // Hold the previous sample
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

   // Capture the lane peak on each transfer
   always_ff @(posedge clock) begin
      if (load) begin
         peak_ff <= peak_in;
      end
   end

   assign peak = peak_ff;

endmodule
`default_nettype wire

// ===== rtl/stph_merge.sv =====
// Merge stage: combines lane peaks, tracks the block maximum and the decaying hold.
`default_nettype none
module stph_merge
   import stph_pkg::*;
#(
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire stage_ctrl_type         stage,
   input  wire logic                   advance,
   input  wire logic                   rsp_ready,
   input  wire logic [DECAY_BITS-1:0]  decay_factor,
   input  wire logic [SAMPLE_BITS-1:0] peak_left,
   input  wire logic [SAMPLE_BITS-1:0] peak_right,
   output logic                        rsp_valid,
   output logic      [SAMPLE_BITS-1:0] rsp_held_peak,
   output logic      [SAMPLE_BITS-1:0] rsp_block_peak
);

   logic                              load;
   logic [SAMPLE_BITS-1:0]            run_ff;
   logic [SAMPLE_BITS-1:0]            run_in;
   logic [SAMPLE_BITS-1:0]            held_ff;
   logic [SAMPLE_BITS-1:0]            held_in;
   logic [SAMPLE_BITS-1:0]            blk;
   logic [SAMPLE_BITS+DECAY_BITS-1:0] product;
   logic [SAMPLE_BITS-1:0]            decayed;
   logic                              valid_ff;
   logic                              valid_in;
   logic [SAMPLE_BITS-1:0]            held_out_ff;
   logic [SAMPLE_BITS-1:0]            block_out_ff;

   assign load = advance && stage.valid;

   // Decay the held peak by the 16-bit fraction, rounding down
   assign product = (SAMPLE_BITS+DECAY_BITS)'(held_ff) * (SAMPLE_BITS+DECAY_BITS)'(decay_factor);
   assign decayed = product[SAMPLE_BITS+DECAY_BITS-1:DECAY_BITS];

   // Fold both lanes into the running block maximum
   always_comb begin
      blk = run_ff;
      if (peak_left > blk) begin
         blk = peak_left;
      end
      if (peak_right > blk) begin
         blk = peak_right;
      end
      run_in  = run_ff;
      held_in = held_ff;
      if (load) begin
         if (stage.block_end) begin
            held_in = (blk > decayed) ? blk : decayed;
            run_in  = '0;
         end else begin
            run_in = blk;
         end
      end
   end

   // Output valid: set on a new result, drop once the transfer completes
   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= '0;
         held_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         run_ff   <= run_in;
         held_ff  <= held_in;
         valid_ff <= valid_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (load) begin
         held_out_ff  <= held_in;
         block_out_ff <= blk;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_held_peak  = held_out_ff;
   assign rsp_block_peak = block_out_ff;

endmodule
`default_nettype wire

// ===== rtl/stereo_true_peak_hold.sv =====
// Top level of the stereo true-peak meter with decaying held peak.
`default_nettype none
// Takes one stereo sample pair per cycle unless the result side stalls and
// returns one result per pair via the lane peak and stage registers, then the
// result register. Each enabled channel lane forms three linearly interpolated
// points between its previous and current sample (4x oversampling) plus the
// sample itself and registers the largest magnitude; the merge stage folds both
// lanes into the block maximum and, on a block end, sets the held peak to the
// larger of that maximum and the decayed held peak in the same cycle, giving
// one pair per clock. The result register lets a new pair enter while a
// finished result waits. No memory, no clearing pass; lane and result peak
// registers are not reset. Write configuration only while the block is idle.
module stereo_true_peak_hold
   import stph_pkg::*;
#(
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  wire logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  wire logic                          req_block_end,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic             [SAMPLE_BITS-1:0] rsp_held_peak,
   output logic             [SAMPLE_BITS-1:0] rsp_block_peak,
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire logic        [DECAY_BITS-1:0]  csr_wdata
);

   logic [DECAY_BITS-1:0]  decay_ff;
   logic [DECAY_BITS-1:0]  decay_in;
   logic [1:0]             enable_ff;
   logic [1:0]             enable_in;
   stage_ctrl_type         stage_ff;
   stage_ctrl_type         stage_in;
   logic                   advance;
   logic                   accept;
   logic [SAMPLE_BITS-1:0] peak_left;
   logic [SAMPLE_BITS-1:0] peak_right;

   // Configuration writes
   always_comb begin
      decay_in  = decay_ff;
      enable_in = enable_ff;
      if (csr_we) begin
         case (csr_index)
            REG_DECAY_FACTOR:   decay_in  = csr_wdata;
            REG_CHANNEL_ENABLE: enable_in = csr_wdata[1:0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff  <= DECAY_BITS'(65533);
         enable_ff <= 2'b11;
      end else begin
         decay_ff  <= decay_in;
         enable_ff <= enable_in;
      end
   end

   // Advance the pipeline whenever the result register can take a new result
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = !stage_ff.valid || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      stage_in = stage_ff;
      if (accept) begin
         stage_in.valid     = 1'b1;
         stage_in.block_end = req_block_end;
      end else if (advance) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   stph_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .enable (enable_ff[0]),
      .sample (req_left_sample),
      .peak   (peak_left)
   );

   stph_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .enable (enable_ff[1]),
      .sample (req_right_sample),
      .peak   (peak_right)
   );

   stph_merge #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_merge (
      .clock          (clock),
      .reset          (reset),
      .stage          (stage_ff),
      .advance        (advance),
      .rsp_ready      (rsp_ready),
      .decay_factor   (decay_ff),
      .peak_left      (peak_left),
      .peak_right     (peak_right),
      .rsp_valid      (rsp_valid),
      .rsp_held_peak  (rsp_held_peak),
      .rsp_block_peak (rsp_block_peak)
   );

endmodule
`default_nettype wire

// ===== tb/stereo_true_peak_hold_test.sv =====
// Testbench for the stereo true-peak hold meter: directed rows, then checked random phases.
`default_nettype none
module stereo_true_peak_hold_test;
   import stph_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_W     = 24;
   localparam int INTERP_RATIO = 4;
   localparam int INTERP_SHIFT = 2;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 10;
   localparam int EXP_DEPTH    = 16;

   localparam logic signed [SAMPLE_W-1:0] MOST_NEG = 24'sh800000;
   localparam logic signed [SAMPLE_W-1:0] MOST_POS = 24'sh7FFFFF;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic        [SAMPLE_W-1:0] mag_type;

   typedef struct packed {
      mag_type held;
      mag_type peak;
   } peak_pair_type;

   // One directed row; fixed rows carry their result typed in.
   typedef struct {
      sample_type    left;
      sample_type    right;
      bit            blk_end;
      bit            fixed;
      peak_pair_type result;
   } pair_row_type;

   // One random phase: register settings, item count, idling and block length.
   typedef struct {
      int decay;
      int enable;
      int count;
      int send_idle;
      int recv_idle;
      int end_pct;
   } phase_type;

   localparam int NUM_ROWS   = 14;
   localparam int NUM_PHASES = 6;

   pair_row_type directed_rows [0:NUM_ROWS-1] = '{
      '{24'sd0,    24'sd0,    1'b0, 1'b1, '{24'd0, 24'd0}},
      '{MOST_NEG,  24'sd0,    1'b1, 1'b1, '{24'd8388608, 24'd8388608}},
      '{MOST_POS,  MOST_NEG,  1'b0, 1'b1, '{24'd8388608, 24'd8388608}},
      '{24'sd0,    24'sd0,    1'b1, 1'b0, '{24'd0, 24'd0}},
      '{24'sd0,    24'sd0,    1'b1, 1'b0, '{24'd0, 24'd0}},
      '{-24'sd1,   24'sd1,    1'b0, 1'b0, '{24'd0, 24'd0}},
      '{24'sd0,    24'sd0,    1'b1, 1'b0, '{24'd0, 24'd0}},
      '{MOST_POS,  MOST_POS,  1'b0, 1'b0, '{24'd0, 24'd0}},
      '{MOST_NEG,  MOST_NEG,  1'b0, 1'b0, '{24'd0, 24'd0}},
      '{24'sd1,    -24'sd1,   1'b1, 1'b0, '{24'd0, 24'd0}},
      '{24'sd0,    24'sd0,    1'b1, 1'b0, '{24'd0, 24'd0}},
      '{24'sd100,  -24'sd100, 1'b0, 1'b0, '{24'd0, 24'd0}},
      '{24'sd0,    24'sd0,    1'b1, 1'b0, '{24'd0, 24'd0}},
      '{24'sd12345, -24'sd54321, 1'b1, 1'b0, '{24'd0, 24'd0}}
   };

   // A negative decay or enable means a random setting.
   phase_type phases [0:NUM_PHASES-1] = '{
      '{65535, 1,  250, 37, 80, 15},
      '{0,     2,  250, 37, 80, 10},
      '{32768, 0,  60,  80, 37, 20},
      '{-1,    3,  300, 80, 37, 5},
      '{65533, 3,  300, 0,  0,  12},
      '{-1,    -1, 380, 0,  0,  30}
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   sample_type          req_left_sample;
   sample_type          req_right_sample;
   logic                req_block_end;
   logic                rsp_valid;
   logic                rsp_ready;
   mag_type             rsp_held_peak;
   mag_type             rsp_block_peak;
   logic                csr_we;
   logic                csr_index;
   logic [DECAY_BITS-1:0] csr_wdata;

   // Predictor state and its copy of the registers.
   sample_type          left_hist;
   sample_type          right_hist;
   mag_type             open_block_max;
   mag_type             held_mag;
   logic [DECAY_BITS-1:0] decay_mult;
   logic [1:0]          lane_enable;

   // Expected results in order: written by the driver, read by the checker.
   peak_pair_type       expected_peaks [0:EXP_DEPTH-1];
   int                  exp_wr_count = 0;
   int                  exp_rd_count = 0;
   int                  mismatches = 0;
   int                  cycles = 0;
   int                  send_idle_pct;
   int                  recv_idle_pct;
   sample_type          last_left_driven;
   sample_type          last_right_driven;

   stereo_true_peak_hold u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .req_block_end    (req_block_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_held_peak    (rsp_held_peak),
      .rsp_block_peak   (rsp_block_peak),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Largest magnitude among the current sample and the three points before it.
   function automatic mag_type lane_peak(sample_type prev, sample_type curr);
      longint p;
      longint c;
      longint point;
      longint best;
      p = prev;
      c = curr;
      best = (c < 0) ? -c : c;
      for (int k = 1; k < INTERP_RATIO; k++) begin
         point = ((INTERP_RATIO - k) * p + k * c) >>> INTERP_SHIFT;
         if (point < 0)
            point = -point;
         if (point > best)
            best = point;
      end
      return best[SAMPLE_W-1:0];
   endfunction

   // Advance the meter by one pair and return the result it reports.
   function automatic peak_pair_type predict_meter(sample_type l, sample_type r, bit e);
      mag_type       pk;
      logic [63:0]   decayed;
      peak_pair_type result;
      if (lane_enable[0]) begin
         pk = lane_peak(left_hist, l);
         if (pk > open_block_max)
            open_block_max = pk;
         left_hist = l;
      end
      if (lane_enable[1]) begin
         pk = lane_peak(right_hist, r);
         if (pk > open_block_max)
            open_block_max = pk;
         right_hist = r;
      end
      result.peak = open_block_max;
      if (e) begin
         decayed = ({40'd0, held_mag} * {48'd0, decay_mult}) >> DECAY_BITS;
         held_mag = ({40'd0, open_block_max} > decayed) ? open_block_max
                                                       : decayed[SAMPLE_W-1:0];
         open_block_max = '0;
      end
      result.held = held_mag;
      return result;
   endfunction

   // Pick a sample: full range, small, extremes, or related to the last one.
   function automatic sample_type draw_sample(sample_type prev);
      sample_type s;
      int         m;
      case ($urandom_range(9))
         0, 1, 2, 3: s = sample_type'($urandom);
         4, 5: begin
            m = $urandom_range(0, 1 << $urandom_range(0, 22));
            s = $urandom_range(1) ? sample_type'(-m) : sample_type'(m);
         end
         6: begin
            case ($urandom_range(4))
               0:       s = MOST_NEG;
               1:       s = MOST_POS;
               2:       s = '0;
               3:       s = -24'sd1;
               default: s = 24'sd1;
            endcase
         end
         7: s = -prev;
         8: s = prev + sample_type'($urandom_range(0, 64)) - 24'sd32;
         default: s = prev;
      endcase
      return s;
   endfunction

   // Offer one pair, hold it until the transfer, and log what it must produce.
   task automatic drive_pair(sample_type l, sample_type r, bit e, bit fixed,
                             peak_pair_type typed);
      peak_pair_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_left_sample  <= l;
      req_right_sample <= r;
      req_block_end    <= e;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predicted = predict_meter(l, r, e);
      expected_peaks[exp_wr_count[3:0]] = fixed ? typed : predicted;
      exp_wr_count++;
      last_left_driven  = l;
      last_right_driven = r;
      @(negedge clock);
   endtask

   // Write one register; the block is idle so the predictor takes it at once.
   task automatic write_reg(logic idx, logic [DECAY_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == REG_DECAY_FACTOR)
         decay_mult = data;
      else
         lane_enable = data[1:0];
      @(negedge clock);
   endtask

   // Drop valid and let every expected result come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (exp_wr_count != exp_rd_count)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Receiver side: stall at random with the current idle rate.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check each result transfer against the oldest expectation.
   always @(posedge clock) begin
      peak_pair_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (exp_rd_count == exp_wr_count) begin
            $display("%0t result with nothing expected: held %0d block %0d",
                     $time, rsp_held_peak, rsp_block_peak);
            mismatches++;
         end else begin
            want = expected_peaks[exp_rd_count[3:0]];
            exp_rd_count++;
            if (rsp_held_peak !== want.held) begin
               $display("%0t held_peak expected %0d got %0d",
                        $time, want.held, rsp_held_peak);
               mismatches++;
            end
            if (rsp_block_peak !== want.peak) begin
               $display("%0t block_peak expected %0d got %0d",
                        $time, want.peak, rsp_block_peak);
               mismatches++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("stereo_true_peak_hold: mismatch");
         $finish;
      end
   end

   initial begin
      sample_type l;
      sample_type r;
      bit         e;
      int         decay;
      int         enable;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_left_sample   = '0;
      req_right_sample  = '0;
      req_block_end     = 1'b0;
      csr_we            = 1'b0;
      csr_index         = REG_DECAY_FACTOR;
      csr_wdata         = '0;
      send_idle_pct     = 37;
      recv_idle_pct     = 80;
      left_hist         = '0;
      right_hist        = '0;
      open_block_max    = '0;
      held_mag          = '0;
      decay_mult        = 16'd65533;
      lane_enable       = 2'b11;
      last_left_driven  = '0;
      last_right_driven = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows under the reset settings.
      foreach (directed_rows[i])
         drive_pair(directed_rows[i].left, directed_rows[i].right,
                    directed_rows[i].blk_end, directed_rows[i].fixed,
                    directed_rows[i].result);

      // Random phases, each with fresh register settings.
      foreach (phases[p]) begin
         wait_idle();
         decay  = (phases[p].decay < 0) ? $urandom_range(65535) : phases[p].decay;
         enable = (phases[p].enable < 0) ? $urandom_range(3) : phases[p].enable;
         write_reg(REG_DECAY_FACTOR, DECAY_BITS'(decay));
         write_reg(REG_CHANNEL_ENABLE, DECAY_BITS'(enable));
         send_idle_pct = phases[p].send_idle;
         recv_idle_pct = phases[p].recv_idle;
         repeat (phases[p].count) begin
            l = draw_sample(last_left_driven);
            r = draw_sample(last_right_driven);
            e = ($urandom_range(99) < phases[p].end_pct);
            drive_pair(l, r, e, 1'b0, '0);
         end
      end

      // Drain and let any stray result show up.
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && exp_wr_count == exp_rd_count)
         $display("stereo_true_peak_hold: match");
      else
         $display("stereo_true_peak_hold: mismatch");
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/stph_pkg.sv
rtl/stph_lane.sv
rtl/stph_merge.sv
rtl/stereo_true_peak_hold.sv
tb/stereo_true_peak_hold_test.sv
